[src/psc_pkg.sv]
package psc_pkg;

    // Data and stack sizing
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_OUT_W = 7;
    localparam int CMD_W       = 3;
    localparam int ST_W        = 2;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // Stream packing
    localparam int OUT_FIELD_W = DATA_W + DEPTH_OUT_W + 1 + ST_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEG  = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_UNDER   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_DIV,
        S_DFIN,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic            load_in;
        logic            push;
        logic            neg;
        logic            rd_issue;
        logic            alu_wb;
        logic            div_start;
        logic            div_step;
        logic            div_wb;
        logic            st_wr;
        logic [ST_W-1:0] st_code;
        logic            out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             cnt_zero;
        logic             cnt_lt2;
        logic             cnt_full;
        logic             top_zero;
        logic             div_last;
    } t_dp_stat;

endpackage

[src/psc_ram.sv]
module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/psc_dp.sv]
module psc_dp
    import psc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [CMD_W-1:0]       i_op,
    input  logic [DATA_W-1:0]      i_push_value,
    output t_dp_stat               o_stat,
    output logic [DATA_W-1:0]      o_top_value,
    output logic [DEPTH_OUT_W-1:0] o_depth,
    output logic                   o_is_empty,
    output logic [ST_W-1:0]        o_status
);

    // Top entry lives in r_top; entries below it live in the RAM
    logic [CMD_W-1:0]       r_op;
    logic [DATA_W-1:0]      r_pv;
    logic [CNT_W-1:0]       r_count;
    logic [DATA_W-1:0]      r_top;
    logic [ST_W-1:0]        r_status;
    logic [DATA_W-1:0]      r_rem;
    logic [DATA_W-1:0]      r_quo;
    logic [DATA_W-1:0]      r_dvs;
    logic                   r_neg_q;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [DATA_W-1:0]      r_out_top;
    logic [DEPTH_OUT_W-1:0] r_out_depth;
    logic                   r_out_empty;
    logic [ST_W-1:0]        r_out_status;

    logic [DATA_W-1:0]      w_left;
    logic [2*DATA_W-1:0]    w_prod;
    logic [DATA_W-1:0]      w_alu;
    logic [DATA_W:0]        w_trial;
    logic [DATA_W-1:0]      w_mag_l;
    logic [DATA_W-1:0]      w_mag_r;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [ADDR_W-1:0]      w_raddr;
    logic                   w_cnt_zero;

    assign w_cnt_zero = (r_count == '0);

    // Stack store below the top entry
    assign w_we    = i_cmd.push && !w_cnt_zero;
    assign w_waddr = ADDR_W'(r_count - CNT_W'(1));
    assign w_raddr = ADDR_W'(r_count - CNT_W'(2));

    psc_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_top),
        .i_raddr(w_raddr),
        .o_rdata(w_left)
    );

    // Add, subtract, multiply (second entry is the left operand)
    assign w_prod = w_left * r_top;
    always_comb begin
        case (r_op)
            CMD_ADD: w_alu = w_left + r_top;
            CMD_SUB: w_alu = w_left - r_top;
            CMD_MUL: w_alu = w_prod[DATA_W-1:0];
            default: w_alu = r_top;
        endcase
    end

    // Divider operand magnitudes and restoring trial subtract
    assign w_mag_l = w_left[DATA_W-1] ? (DATA_W'(0) - w_left) : w_left;
    assign w_mag_r = r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
    assign w_trial = {r_rem, r_quo[DATA_W-1]} - {1'b0, r_dvs};

    // Stack control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.alu_wb || i_cmd.div_wb) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op <= i_op;
            r_pv <= i_push_value;
        end
        if (i_cmd.st_wr) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.push) begin
            r_top <= r_pv;
        end else if (i_cmd.neg) begin
            r_top <= DATA_W'(0) - r_top;
        end else if (i_cmd.alu_wb) begin
            r_top <= w_alu;
        end else if (i_cmd.div_wb) begin
            r_top <= r_neg_q ? (DATA_W'(0) - r_quo) : r_quo;
        end
        // Divider: one quotient bit per cycle
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= w_mag_l;
            r_dvs     <= w_mag_r;
            r_neg_q   <= w_left[DATA_W-1] ^ r_top[DATA_W-1];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        // Result register
        if (i_cmd.out_load) begin
            r_out_top    <= w_cnt_zero ? '0 : r_top;
            r_out_depth  <= DEPTH_OUT_W'(r_count);
            r_out_empty  <= w_cnt_zero;
            r_out_status <= r_status;
        end
    end

    // Status to controller
    assign o_stat.op       = r_op;
    assign o_stat.cnt_zero = w_cnt_zero;
    assign o_stat.cnt_lt2  = (r_count < CNT_W'(2));
    assign o_stat.cnt_full = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.div_last = (r_div_cnt == DIV_CNT_W'(DATA_W - 1));

    assign o_top_value = r_out_top;
    assign o_depth     = r_out_depth;
    assign o_is_empty  = r_out_empty;
    assign o_status    = r_out_status;

endmodule

[src/psc_ctrl.sv]
module psc_ctrl
    import psc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.st_code = ST_OK;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.st_wr = 1'b1;
                n_state     = S_OUT;
                case (i_stat.op)
                    CMD_PUSH: begin
                        if (i_stat.cnt_full) begin
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    CMD_NEG: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.st_code = ST_UNDER;
                        end else begin
                            o_cmd.neg = 1'b1;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL: begin
                        if (i_stat.cnt_lt2) begin
                            o_cmd.st_code = ST_UNDER;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    CMD_DIV: begin
                        if (i_stat.cnt_lt2) begin
                            o_cmd.st_code = ST_UNDER;
                        end else if (i_stat.top_zero) begin
                            o_cmd.st_code = ST_DIVZERO;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        o_cmd.st_code = ST_OK;
                    end
                endcase
            end
            S_READ: begin
                if (i_stat.op == CMD_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.alu_wb = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.div_wb = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // wait for the result register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/postfix_stack_calculator_unit.sv]
// Reverse Polish integer calculator over a 64-entry stack of 32-bit values.
// Input channel (s_axis): one item per command. tuser carries the command
// code (push, add, subtract, multiply, divide, negate), tdata the signed
// value used by push. Output channel (m_axis): one item per command with
// the new top value (zero when empty), depth, empty flag and status.
// Subtract and divide take the second entry as the left operand.
// Path from accept to result valid: push, negate, unused codes and all error
// cases pass decode and output; add, subtract and multiply add one stack RAM
// read; divide adds the read, the restoring divider that retires one quotient
// bit per cycle, and its write-back. One command is processed at a time; the
// next is accepted in the cycle after the previous result is loaded into the
// output register.
// Reset clears the stack depth and the output valid; stack contents are not
// cleared and are never read before being written.
// While the receiver stalls, the result holds in the output register; one
// more command can be accepted and computed, and it then waits until the
// pending result is taken.
module postfix_stack_calculator_unit
    import psc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,  // [31:0] push_value
    input  logic [CMD_W-1:0]       s_axis_tuser,  // [2:0] cmd
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] top_value, [38:32] depth, [39] is_empty, [41:40] status, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic [DATA_W-1:0]      w_top_value;
    logic [DEPTH_OUT_W-1:0] w_depth;
    logic                   w_is_empty;
    logic [ST_W-1:0]        w_status;

    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    psc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (s_axis_tuser),
        .i_push_value(s_axis_tdata),
        .o_stat      (w_stat),
        .o_top_value (w_top_value),
        .o_depth     (w_depth),
        .o_is_empty  (w_is_empty),
        .o_status    (w_status)
    );

    // Pack result fields, first field lowest
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_status, w_is_empty, w_depth, w_top_value};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import psc_pkg::*;

    // Run control
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 240;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 48;

    // Command codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // Random segment flavors
    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIXED = 2;
    localparam int SEG_NOISE = 3;

    // One result item, unpacked
    typedef struct packed {
        logic [DATA_W-1:0]      top;
        logic [DEPTH_OUT_W-1:0] depth;
        logic                   empty;
        logic [ST_W-1:0]        st;
    } t_answer;

    // One row of the directed table
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] val;
        logic              typed;
        t_answer           ans;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;   // [31:0] push_value
    logic [CMD_W-1:0]       s_axis_tuser;   // [2:0] cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [31:0] top_value, [38:32] depth, [39] is_empty, [41:40] status, rest zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow stack of the calculator
    logic [DATA_W-1:0] calc_mem [STACK_DEPTH];
    int                calc_count = 0;
    int                calc_peak = 0;

    t_answer  pending_answers [$];
    t_dir_row dir_rows [$];

    int err_count     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_asked    = 0;
    int hold_given    = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    postfix_stack_calculator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Report one mismatch and count it
    task automatic flag_mismatch(input string what, input logic [OUT_TDATA_W-1:0] got,
                                 input logic [OUT_TDATA_W-1:0] want);
        err_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Apply one command to the shadow stack and return the answer
    task automatic calc_step(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                             output t_answer ans);
        logic [DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
        logic [ST_W-1:0]   st;
        st  = ST_OK;
        res = '0;
        if (op == CMD_PUSH) begin
            if (calc_count >= STACK_DEPTH) begin
                st = ST_FULL;
            end else begin
                calc_mem[calc_count] = val;
                calc_count++;
            end
        end else if (op == CMD_NEG) begin
            if (calc_count < 1) begin
                st = ST_UNDER;
            end else begin
                calc_mem[calc_count-1] = -calc_mem[calc_count-1];
            end
        end else if (op >= CMD_ADD && op <= CMD_DIV) begin
            if (calc_count < 2) begin
                st = ST_UNDER;
            end else begin
                rhs = calc_mem[calc_count-1];
                lhs = calc_mem[calc_count-2];
                case (op)
                    CMD_ADD: res = lhs + rhs;
                    CMD_SUB: res = lhs - rhs;
                    CMD_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            st = ST_DIVZERO;
                        end else begin
                            // truncate toward zero via magnitudes
                            mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                            mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                            quo   = mag_l / mag_r;
                            res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
                        end
                    end
                endcase
                if (st == ST_OK) begin
                    calc_mem[calc_count-2] = res;
                    calc_count--;
                end
            end
        end
        if (calc_count > calc_peak) calc_peak = calc_count;
        ans.top   = (calc_count > 0) ? calc_mem[calc_count-1] : '0;
        ans.depth = DEPTH_OUT_W'(calc_count);
        ans.empty = (calc_count == 0);
        ans.st    = st;
    endtask

    // Offer one command item; prediction is taken at acceptance
    task automatic offer_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                             input logic typed, input t_answer typed_ans);
        t_answer pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        calc_step(op, val, pred);
        pending_answers.push_back(typed ? typed_ans : pred);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic add_dir(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic typed, input logic [DATA_W-1:0] top,
                           input logic [DEPTH_OUT_W-1:0] depth, input logic [ST_W-1:0] st);
        t_dir_row row;
        row.op        = op;
        row.val       = val;
        row.typed     = typed;
        row.ans.top   = top;
        row.ans.depth = depth;
        row.ans.empty = (depth == '0);
        row.ans.st    = st;
        dir_rows.push_back(row);
    endtask

    // Operand mix: corners, small values, full random
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] rand_arith();
        case ($urandom_range(0, 5))
            0:       return CMD_ADD;
            1:       return CMD_SUB;
            2:       return CMD_MUL;
            3, 4:    return CMD_DIV;
            default: return CMD_NEG;
        endcase
    endfunction

    // Receiver: random ready, with an occasional long hold-off
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_asked != hold_given) begin
                hold_given++;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                flag_mismatch("result with nothing pending", m_axis_tdata, '0);
            end else begin
                want = pending_answers.pop_front();
                status_seen[want.st]++;
                if (m_axis_tdata[0 +: DATA_W] !== want.top)
                    flag_mismatch("top_value", m_axis_tdata[0 +: DATA_W], want.top);
                if (m_axis_tdata[DATA_W +: DEPTH_OUT_W] !== want.depth)
                    flag_mismatch("depth", m_axis_tdata[DATA_W +: DEPTH_OUT_W], want.depth);
                if (m_axis_tdata[DATA_W+DEPTH_OUT_W] !== want.empty)
                    flag_mismatch("is_empty", m_axis_tdata[DATA_W+DEPTH_OUT_W], want.empty);
                if (m_axis_tdata[DATA_W+DEPTH_OUT_W+1 +: ST_W] !== want.st)
                    flag_mismatch("status", m_axis_tdata[DATA_W+DEPTH_OUT_W+1 +: ST_W],
                                  want.st);
                if (m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                    flag_mismatch("pad bits", m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], '0);
            end
        end
    end

    // Stimulus
    initial begin
        int       mode;
        int       seg_len;
        int       target;
        int       extra;
        logic [CMD_W-1:0] op;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUSH;
        i_rst_n       = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: empty-stack errors, extremes, wrap cases
        add_dir(CMD_ADD,   $urandom,        1, '0,           7'd0, ST_UNDER);
        add_dir(CMD_NEG,   $urandom,        1, '0,           7'd0, ST_UNDER);
        add_dir(CMD_DIV,   $urandom,        1, '0,           7'd0, ST_UNDER);
        add_dir(CMD_RSVD6, $urandom,        1, '0,           7'd0, ST_OK);
        add_dir(CMD_PUSH,  32'h8000_0000,   1, 32'h8000_0000, 7'd1, ST_OK);
        add_dir(CMD_SUB,   $urandom,        1, 32'h8000_0000, 7'd1, ST_UNDER);
        // negating the most negative value gives itself
        add_dir(CMD_NEG,   $urandom,        1, 32'h8000_0000, 7'd1, ST_OK);
        add_dir(CMD_PUSH,  '1,              1, '1,            7'd2, ST_OK);
        // most negative over minus one wraps
        add_dir(CMD_DIV,   $urandom,        1, 32'h8000_0000, 7'd1, ST_OK);
        add_dir(CMD_PUSH,  '0,              1, '0,            7'd2, ST_OK);
        add_dir(CMD_DIV,   $urandom,        1, '0,            7'd2, ST_DIVZERO);
        add_dir(CMD_MUL,   $urandom,        1, '0,            7'd1, ST_OK);
        add_dir(CMD_PUSH,  32'h7FFF_FFFF,   1, 32'h7FFF_FFFF, 7'd2, ST_OK);
        add_dir(CMD_ADD,   $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_PUSH,  32'd1,           0, '0, '0, ST_OK);
        add_dir(CMD_ADD,   $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_PUSH,  32'd7,           0, '0, '0, ST_OK);
        add_dir(CMD_PUSH,  -32'sd2,         0, '0, '0, ST_OK);
        add_dir(CMD_DIV,   $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_PUSH,  32'd5,           0, '0, '0, ST_OK);
        add_dir(CMD_SUB,   $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_RSVD7, $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_PUSH,  -32'sd7,         0, '0, '0, ST_OK);
        add_dir(CMD_MUL,   $urandom,        0, '0, '0, ST_OK);
        add_dir(CMD_NEG,   $urandom,        0, '0, '0, ST_OK);

        src_idle_pct  = 28;
        sink_idle_pct = 74;
        foreach (dir_rows[i])
            offer_cmd(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, dir_rows[i].ans);

        // Random phases with different idling on each side
        for (int ph = 0; ph < 3; ph++) begin
            drain_results();
            src_idle_pct  = (ph == 0) ? 28 : (ph == 1) ? 74 : 0;
            sink_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 28 : 0;
            // long receiver stall while items keep coming
            if (ph == 2) hold_asked++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                mode = $urandom_range(SEG_FILL, SEG_NOISE);
                if (mode == SEG_FILL) begin
                    // climb to full, then push into a full stack
                    while (calc_count < STACK_DEPTH) begin
                        op = ($urandom_range(0, 99) < 92) ? CMD_PUSH : rand_arith();
                        offer_cmd(op, rand_value(), 0, '0);
                    end
                    extra = $urandom_range(1, 3);
                    repeat (extra) offer_cmd(CMD_PUSH, rand_value(), 0, '0);
                end else if (mode == SEG_DRAIN) begin
                    // fold down to one entry, then run past the bottom
                    while (calc_count > 1) begin
                        op = ($urandom_range(0, 99) < 85) ? rand_arith() : CMD_PUSH;
                        offer_cmd(op, rand_value(), 0, '0);
                    end
                    extra = $urandom_range(1, 3);
                    repeat (extra) offer_cmd(rand_arith(), rand_value(), 0, '0);
                end else begin
                    seg_len = $urandom_range(20, 60);
                    repeat (seg_len) begin
                        if (mode == SEG_MIXED)
                            op = ($urandom_range(0, 1) == 0) ? CMD_PUSH : rand_arith();
                        else
                            op = CMD_W'($urandom_range(0, 7));
                        offer_cmd(op, rand_value(), 0, '0);
                    end
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("sent %0d commands, checked %0d results, peak depth %0d", items_sent,
                 results_seen, calc_peak);
        $display("status counts: ok %0d, underflow %0d, full %0d, divide by zero %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
